// File: rtl/core/rrg_pkg.sv
// Package for the record request gate: request, state and action types,
// action and register codes, and reset values. No dependencies.
`timescale 1ns / 1ps

package rrg_pkg;

	localparam int unsigned TIME_W     = 32;
	localparam int unsigned CFG_W      = 16;
	localparam int unsigned CFG_ADDR_W = 8;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 8;

	typedef logic [1:0] action_t;

	localparam action_t ACT_NONE   = 2'd0;
	localparam action_t ACT_START  = 2'd1;
	localparam action_t ACT_STOP   = 2'd2;
	localparam action_t ACT_CANCEL = 2'd3;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_ABORT  = 1'b1;

	localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RECORD = 8'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_COOLDOWN   = 8'd1;

	localparam logic [CFG_W-1:0] MIN_RECORD_RST = 16'd300;
	localparam logic [CFG_W-1:0] COOLDOWN_RST   = 16'd500;

	typedef struct packed {
		logic              req_type;
		logic              want;
		logic              recog_busy;
		logic              hard_stop;
		logic [TIME_W-1:0] now_ms;
	} gate_req_t;

	typedef struct packed {
		logic              want_before;
		logic              is_recording;
		logic              holding_off;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] stop_time;
	} gate_state_t;

	localparam gate_state_t GATE_STATE_RST = '{
		want_before:  1'b0,
		is_recording: 1'b0,
		holding_off:  1'b0,
		start_time:   '0,
		stop_time:    '0
	};

endpackage

// File: rtl/core/rrg_decide.sv
// Decision logic of the record request gate: from the current gate state and
// one request, the action and the next gate state. Depends on rrg_pkg.
`timescale 1ns / 1ps

module rrg_decide import rrg_pkg::*; (
	input  gate_req_t         req,
	input  gate_state_t       state,
	input  logic [CFG_W-1:0]  min_record_ms,
	input  logic [CFG_W-1:0]  cooldown_ms,
	output gate_state_t       state_nxt,
	output action_t           action
);

	logic [TIME_W-1:0] run_time;
	logic [TIME_W-1:0] since_stop;
	logic              rising;
	logic              min_done;
	logic              cooling;

	// Differences wrap modulo 2^32 by plain truncating subtraction.
	assign run_time   = req.now_ms - state.start_time;
	assign since_stop = req.now_ms - state.stop_time;
	assign rising     = req.want & ~state.want_before;
	assign min_done   = run_time >= {{(TIME_W-CFG_W){1'b0}}, min_record_ms};
	// A stop time of zero stands for never stopped.
	assign cooling    = (state.stop_time != '0) &&
	                    (since_stop < {{(TIME_W-CFG_W){1'b0}}, cooldown_ms});

	always_comb begin
		state_nxt = state;
		action    = ACT_NONE;
		if (req.req_type == REQ_ABORT) begin
			state_nxt.is_recording = 1'b0;
			state_nxt.holding_off  = 1'b1;
			state_nxt.stop_time    = req.now_ms;
		end else begin
			state_nxt.want_before = req.want;
			// Hold-off swallows the event until want is seen low.
			if (!(state.holding_off && req.want)) begin
				state_nxt.holding_off = 1'b0;
				if (state.is_recording) begin
					if (req.hard_stop || (!req.want && min_done)) begin
						state_nxt.is_recording = 1'b0;
						state_nxt.stop_time    = req.now_ms;
						state_nxt.holding_off  = req.hard_stop;
						action                 = ACT_STOP;
					end
				end else if (req.want && rising) begin
					if (req.recog_busy) begin
						state_nxt.holding_off = 1'b1;
						action                = ACT_CANCEL;
					end else if (!cooling) begin
						state_nxt.is_recording = 1'b1;
						state_nxt.start_time   = req.now_ms;
						action                 = ACT_START;
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/record_request_gate_top.sv
// Top level of the record request gate: input register, gate state and
// configuration registers, result register. Depends on rrg_pkg, rrg_decide.
`timescale 1ns / 1ps

// The gate takes one event word per clock while the output is not stalled and
// returns exactly one action word per event, via the input and result registers.
// The throughput of one word per cycle is set by the combinational decision path
// from the input register through the gate state to the result register; the
// gate state is updated as the event moves into the result register, so back
// to back events see each other's effect. Configuration writes are taken in
// any cycle and are meant to be made while no event is in flight.
module record_request_gate_top import rrg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // want, recog_busy, hard_stop, now_ms[31:0], zero pad
	input  logic                  s_tuser,  // req_type
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // action[1:0], zero pad
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data
);

	gate_req_t        req_s1;
	logic             valid_s1;
	action_t          action_q;
	logic             out_valid_q;
	gate_state_t      state_q;
	gate_state_t      state_nxt;
	action_t          action_nxt;
	logic [CFG_W-1:0] min_record_q;
	logic [CFG_W-1:0] cooldown_q;
	logic             out_free;
	logic             take_s1;
	logic             in_accept;

	assign out_free  = ~out_valid_q | m_tready;
	assign take_s1   = valid_s1 & out_free;
	assign s_tready  = ~valid_s1 | out_free;
	assign in_accept = s_tvalid & s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, action_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_s1.req_type   <= s_tuser;
			req_s1.want       <= s_tdata[0];
			req_s1.recog_busy <= s_tdata[1];
			req_s1.hard_stop  <= s_tdata[2];
			req_s1.now_ms     <= s_tdata[TIME_W+2:3];
		end
	end

	rrg_decide u_decide (
		.req           (req_s1),
		.state         (state_q),
		.min_record_ms (min_record_q),
		.cooldown_ms   (cooldown_q),
		.state_nxt     (state_nxt),
		.action        (action_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= GATE_STATE_RST;
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= take_s1;
			if (take_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			action_q <= action_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_record_q <= MIN_RECORD_RST;
			cooldown_q   <= COOLDOWN_RST;
		end else if (cfg_valid) begin
			if (cfg_addr == CFG_MIN_RECORD) begin
				min_record_q <= cfg_data;
			end else if (cfg_addr == CFG_COOLDOWN) begin
				cooldown_q <= cfg_data;
			end
		end
	end

endmodule

// File: rtl/core/rrg_checker.sv
// Port-level checker for the record request gate and its bind to the top
// level. Depends on rrg_pkg and record_request_gate_top.
`timescale 1ns / 1ps

module rrg_port_checker import rrg_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	// Words accepted at the input whose action word has not yet left.
	logic [1:0] pending_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("action word changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("action word shown with no event in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd2 |-> !(in_acc && !out_acc))
		else $error("more than two events in flight");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:2] == '0)
		else $error("action word padding not zero");

endmodule

bind record_request_gate_top rrg_port_checker u_rrg_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: verif/rrg_checker.sv
// Checker for the record request gate: watches the event, action and register
// channels, predicts each action and compares it. Depends on rrg_pkg.
`timescale 1ns / 1ps

module rrg_checker import rrg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]      cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    result_count,
	output int                    start_count,
	output int                    stop_count,
	output int                    cancel_count
);

	gate_state_t      gate;
	logic [CFG_W-1:0] min_rec;
	logic [CFG_W-1:0] cooldown;
	action_t          expected_actions[$];
	int               errs;
	int               n_res;
	int               n_start;
	int               n_stop;
	int               n_cancel;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		errs++;
	endtask

	// Works out the action of one event and moves the gate state along.
	function automatic action_t gate_decide(input gate_req_t ev);
		logic        rising;
		logic [31:0] rec_elapsed;
		logic [31:0] stop_elapsed;
		if (ev.req_type == REQ_ABORT) begin
			gate.is_recording = 1'b0;
			gate.holding_off  = 1'b1;
			gate.stop_time    = ev.now_ms;
			return ACT_NONE;
		end
		rising = ev.want && !gate.want_before;
		gate.want_before = ev.want;
		if (gate.holding_off) begin
			if (ev.want)
				return ACT_NONE;
			gate.holding_off = 1'b0;
		end
		rec_elapsed  = ev.now_ms - gate.start_time;
		stop_elapsed = ev.now_ms - gate.stop_time;
		if (gate.is_recording) begin
			if (ev.hard_stop || (!ev.want && rec_elapsed >= {16'd0, min_rec})) begin
				gate.is_recording = 1'b0;
				gate.stop_time    = ev.now_ms;
				if (ev.hard_stop)
					gate.holding_off = 1'b1;
				return ACT_STOP;
			end
			return ACT_NONE;
		end
		if (!ev.want)
			return ACT_NONE;
		if (ev.recog_busy) begin
			if (rising) begin
				gate.holding_off = 1'b1;
				return ACT_CANCEL;
			end
			return ACT_NONE;
		end
		if (!rising)
			return ACT_NONE;
		// A stop time of zero reads as never stopped, so no cooldown applies.
		if (gate.stop_time != '0 && stop_elapsed < {16'd0, cooldown})
			return ACT_NONE;
		gate.is_recording = 1'b1;
		gate.start_time   = ev.now_ms;
		return ACT_START;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gate_req_t ev;
		action_t   got;
		action_t   want_act;
		if (!arst_n) begin
			gate     = GATE_STATE_RST;
			min_rec  = MIN_RECORD_RST;
			cooldown = COOLDOWN_RST;
			expected_actions.delete();
			errs     = 0;
			n_res    = 0;
			n_start  = 0;
			n_stop   = 0;
			n_cancel = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_MIN_RECORD: min_rec = cfg_data;
					CFG_COOLDOWN:   cooldown = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[1:0];
				n_res++;
				case (got)
					ACT_START:  n_start++;
					ACT_STOP:   n_stop++;
					ACT_CANCEL: n_cancel++;
					default: ;
				endcase
				if (expected_actions.size() == 0) begin
					report_mismatch($sformatf("action word %0d with no event outstanding", got));
				end else begin
					want_act = expected_actions.pop_front();
					if (got !== want_act)
						report_mismatch($sformatf("action word %0d: got %0d, predicted %0d",
							n_res, got, want_act));
				end
			end
			if (s_tvalid && s_tready) begin
				ev.req_type   = s_tuser;
				ev.want       = s_tdata[0];
				ev.recog_busy = s_tdata[1];
				ev.hard_stop  = s_tdata[2];
				ev.now_ms     = s_tdata[34:3];
				expected_actions.push_back(gate_decide(ev));
			end
		end
		fail_count   <= errs;
		pending      <= expected_actions.size();
		result_count <= n_res;
		start_count  <= n_start;
		stop_count   <= n_stop;
		cancel_count <= n_cancel;
	end

endmodule

// File: verif/tb_record_request_gate_top.sv
// Testbench top for record_request_gate_top: clock, reset, event and register
// stimulus with random idling, and the verdict. Depends on rrg_pkg, rrg_checker and record_request_gate_top.
`timescale 1ns / 1ps

module tb_record_request_gate_top;
	import rrg_pkg::*;

	localparam int N_PHASES   = 9;
	localparam int PHASE_LEN  = 172;
	localparam int LONG_HOLD  = 400;
	localparam int HOLD_PHASE = 3;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_W-1:0]      cfg_data;

	int fail_count;
	int pending;
	int result_count;
	int start_count;
	int stop_count;
	int cancel_count;

	bit          quiet;
	bit          long_hold_req;
	logic        want_lvl;
	logic [31:0] cur_ms;
	int unsigned ph_min[N_PHASES];
	int unsigned ph_cool[N_PHASES];

	record_request_gate_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	rrg_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count),
		.start_count  (start_count),
		.stop_count   (stop_count),
		.cancel_count (cancel_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Action side: random stalls, one long hold-off on request, none when quiet.
	initial begin
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold_req = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Offers one event word and returns at the edge that takes it.
	task automatic send_event(input logic kind, input logic w, input logic busy,
			input logic stop_req, input logic [31:0] now);
		logic [IN_DATA_W-1:0] word;
		word        = '0;
		word[0]     = w;
		word[1]     = busy;
		word[2]     = stop_req;
		word[34:3]  = now;
		s_tvalid   <= 1'b1;
		s_tdata    <= word;
		s_tuser    <= kind;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(input int unsigned th);
		int unsigned pick;
		logic        kind;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			cur_ms = cur_ms + $urandom_range(0, 8);
		else if (pick < 8)
			cur_ms = cur_ms + $urandom_range(0, 2 * th + 4);
		else if (pick == 8)
			cur_ms = cur_ms + $urandom_range(0, 300000);
		else
			cur_ms = $urandom_range(0, 1) ? $urandom : 32'd0;
		if ($urandom_range(0, 4) < 2)
			want_lvl = ~want_lvl;
		kind = ($urandom_range(0, 24) == 0) ? REQ_ABORT : REQ_UPDATE;
		send_event(kind, want_lvl, $urandom_range(0, 4) == 0, $urandom_range(0, 11) == 0,
			cur_ms);
	endtask

	// Stops offering events and waits until every predicted action has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned min_val, input int unsigned cool_val);
		cfg_valid <= 1'b1;
		cfg_addr  <= CFG_MIN_RECORD;
		cfg_data  <= min_val[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_addr  <= CFG_COOLDOWN;
		cfg_data  <= cool_val[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int unsigned th;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = REQ_UPDATE;
		cfg_valid     = 1'b0;
		cfg_addr      = CFG_MIN_RECORD;
		cfg_data      = '0;
		quiet         = 1'b0;
		long_hold_req = 1'b0;
		want_lvl      = 1'b0;
		cur_ms        = '0;
		ph_min  = '{0, 65535, 1, 300, 0, 0, 65535, 0, 0};
		ph_cool = '{0, 65535, 1, 500, 0, 0, 0, 65535, 0};
		ph_min[4]  = $urandom_range(0, 2000);
		ph_cool[4] = $urandom_range(0, 2000);
		ph_min[5]  = $urandom_range(0, 2000);
		ph_cool[5] = $urandom_range(0, 2000);
		ph_min[8]  = $urandom_range(0, 2000);
		ph_cool[8] = $urandom_range(0, 2000);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings of 300 ms and 500 ms.
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd0);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'd200);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd499);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd500);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'd999);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd999);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'd1000);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b1, 32'd1001);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'd1002);
		send_event(REQ_UPDATE, 1'b0, 1'b1, 1'b0, 32'd1003);
		send_event(REQ_UPDATE, 1'b1, 1'b1, 1'b0, 32'd1004);
		send_event(REQ_UPDATE, 1'b1, 1'b1, 1'b0, 32'd1005);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd1006);
		// An abort at time zero leaves a stop time of zero, which reads as never stopped.
		send_event(REQ_ABORT,  1'b1, 1'b1, 1'b1, 32'd0);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'd1);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'd2);
		send_event(REQ_ABORT,  1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		// Cooldown measured across the wrap of the clock, then minimum recording at its bound.
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'h0000_01F2);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'h0000_01F2);
		send_event(REQ_UPDATE, 1'b1, 1'b0, 1'b0, 32'h0000_01F3);
		send_event(REQ_UPDATE, 1'b0, 1'b0, 1'b0, 32'h0000_031E);
		send_event(REQ_UPDATE, 1'b0, 1'b1, 1'b0, 32'h0000_031F);
		drain();

		for (int p = 0; p < N_PHASES; p++) begin
			set_config(ph_min[p], ph_cool[p]);
			th = (ph_min[p] > ph_cool[p]) ? ph_min[p] : ph_cool[p];
			if (p % 3 == 1)
				cur_ms = 32'hFFFF_FFFF - $urandom_range(0, 400000);
			else
				cur_ms = $urandom_range(0, 50000);
			quiet = (p == N_PHASES - 1);
			if (p == HOLD_PHASE)
				long_hold_req = 1'b1;
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (!quiet && $urandom_range(0, 5) == 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 16)) @(posedge clk);
				end
				send_random(th);
			end
			drain();
		end

		$display("Checked %0d actions over %0d register settings, including wrap and zero times.",
			result_count, N_PHASES + 1);
		$display("Actions seen: %0d starts, %0d stops, %0d recognizer cancels.",
			start_count, stop_count, cancel_count);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: record_request_gate_top.f
rtl/core/rrg_pkg.sv
rtl/core/rrg_decide.sv
rtl/core/record_request_gate_top.sv
rtl/core/rrg_checker.sv
verif/rrg_checker.sv
verif/tb_record_request_gate_top.sv
